### hw/rtl/thop_pkg.sv
package thop_pkg;

   localparam int MaxHeaderBytes = 60;
   localparam int LocalWindowWidth = 30;
   localparam int LocalScaleWidth = 4;
   localparam int CsrDataWidth = 30;
   localparam logic [15:0] DefaultMss = 16'd1460;
   localparam logic [3:0] MaxScale = 4'd14;
   localparam logic [29:0] ResetLocalWindow = 30'd65535;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      PH_KIND = 2'd0,
      PH_LEN = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   typedef enum logic {
      CSR_LOCAL_WINDOW_SIZE = 1'b0,
      CSR_LOCAL_WINDOW_SCALE = 1'b1
   } csr_index_type;

   localparam logic [7:0] KIND_EOL = 8'd0;
   localparam logic [7:0] KIND_NOP = 8'd1;
   localparam logic [7:0] KIND_MSS = 8'd2;
   localparam logic [7:0] KIND_WSCALE = 8'd3;
   localparam logic [7:0] KIND_SACK_OK = 8'd4;
   localparam logic [7:0] KIND_SACK = 8'd5;
   localparam logic [7:0] KIND_TSTAMP = 8'd8;

   // One classified byte handed from the front part to the back part.
   typedef struct packed {
      logic [7:0] data;
      logic last;
      logic [31:0] send_next;
      logic [5:0] pos;
   } item_type;

   // Result fields.
   typedef struct packed {
      logic [29:0] send_window;
      logic [15:0] dup_ack_count;
      logic [31:0] latest_ack;
      logic [15:0] peer_mss;
      logic [7:0] send_scale;
      logic sack_allowed;
      logic [31:0] peer_timestamp;
      logic [31:0] echoed_timestamp;
      logic [3:0] recv_scale;
      logic [29:0] recv_window;
      logic parse_error;
   } result_type;

endpackage

### hw/rtl/thop_front.sv
// Front part: counts the byte position of each header and tags every byte.
module thop_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_header_byte,
   input logic req_last_byte,
   input logic [31:0] req_send_next,
   output logic q_valid,
   input logic q_ready,
   output thop_pkg::item_type q_item
);

   logic [5:0] pos_ff;
   logic [5:0] pos_in;
   logic take;

   assign req_stall = !q_ready;
   assign take = req_valid && q_ready;
   assign q_valid = req_valid;

   always_comb begin
      q_item.data = req_header_byte;
      q_item.last = req_last_byte;
      q_item.send_next = req_send_next;
      q_item.pos = pos_ff;
   end

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         if (req_last_byte) begin
            pos_in = 6'd0;
         end else if (pos_ff != 6'd63) begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 6'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

### hw/rtl/thop_queue.sv
// Small queue between the front and back parts.
module thop_queue #(
   parameter int Depth = thop_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input thop_pkg::item_type in_item,
   output logic out_valid,
   input logic out_ready,
   output thop_pkg::item_type out_item
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;

   thop_pkg::item_type mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrWidth:0] count_ff, count_in;
   logic push, pop;

   assign in_ready = (count_ff != Depth[PtrWidth:0]);
   assign out_valid = (count_ff != '0);
   assign out_item = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      end
      count_in = count_ff + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

### hw/rtl/thop_back.sv
// Back part: header field extraction, option walk and result register.
module thop_back #(
   parameter int MaxHeaderBytes = thop_pkg::MaxHeaderBytes
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   output logic q_ready,
   input thop_pkg::item_type q_item,
   input logic [29:0] local_window_size,
   input logic [3:0] local_window_scale,
   output logic rsp_valid,
   input logic rsp_stall,
   output thop_pkg::result_type rsp_data
);

   localparam logic [6:0] MaxEnd = 7'(MaxHeaderBytes);

   logic [3:0] words_ff, words_in;
   logic ack_flag_ff, ack_flag_in;
   logic [31:0] ack_num_ff, ack_num_in;
   logic [7:0] win_hi_ff, win_hi_in;
   thop_pkg::phase_type phase_ff, phase_in;
   logic [7:0] kind_ff, kind_in;
   logic [7:0] remain_ff, remain_in;
   logic [7:0] olen_ff, olen_in;
   logic [63:0] acc_ff, acc_in;
   logic stopped_ff, stopped_in;
   logic err_ff, err_in;
   logic [29:0] swin_ff, swin_in;
   logic [31:0] lack_ff, lack_in;
   logic [15:0] dup_ff, dup_in;
   logic [15:0] mss_ff, mss_in;
   logic [7:0] sscale_ff, sscale_in;
   logic sack_ff, sack_in;
   logic [31:0] pts_ff, pts_in;
   logic [31:0] ets_ff, ets_in;
   logic [3:0] rscale_ff, rscale_in;
   logic [29:0] rwin_ff, rwin_in;
   logic out_valid_ff, out_valid_in;
   thop_pkg::result_type out_ff, out_in;

   logic take;
   logic [6:0] end_pos, p7, p_next;
   logic [7:0] b;
   logic [8:0] n9;
   logic [7:0] idx;
   logic [63:0] acc_fin;
   logic finish;
   logic [31:0] val;
   logic [3:0] sh;
   logic [15:0] raw_win;

   assign q_ready = !out_valid_ff || !rsp_stall;
   assign take = q_valid && q_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign b = q_item.data;
   assign p7 = {1'b0, q_item.pos};
   assign p_next = (q_item.pos == 6'd63) ? 7'd63 : p7 + 7'd1;

   always_comb begin
      if (words_ff < 4'd5) begin
         end_pos = 7'd20;
      end else begin
         end_pos = {1'b0, words_ff, 2'b00};
      end
      if (end_pos > MaxEnd) begin
         end_pos = MaxEnd;
      end
   end

   // Value of the first min(n,4) data bytes, big-endian.
   function automatic logic [31:0] opt_value(input logic [63:0] acc, input logic [7:0] n);
      logic [31:0] hi;
      hi = acc[63:32];
      if (n == 8'd0) begin
         opt_value = 32'd0;
      end else if (n == 8'd1) begin
         opt_value = {24'd0, hi[31:24]};
      end else if (n == 8'd2) begin
         opt_value = {16'd0, hi[31:16]};
      end else if (n == 8'd3) begin
         opt_value = {8'd0, hi[31:8]};
      end else begin
         opt_value = hi;
      end
   endfunction

   always_comb begin
      words_in = words_ff;
      ack_flag_in = ack_flag_ff;
      ack_num_in = ack_num_ff;
      win_hi_in = win_hi_ff;
      phase_in = phase_ff;
      kind_in = kind_ff;
      remain_in = remain_ff;
      olen_in = olen_ff;
      acc_in = acc_ff;
      stopped_in = stopped_ff;
      err_in = err_ff;
      swin_in = swin_ff;
      lack_in = lack_ff;
      dup_in = dup_ff;
      mss_in = mss_ff;
      sscale_in = sscale_ff;
      sack_in = sack_ff;
      pts_in = pts_ff;
      ets_in = ets_ff;
      rscale_in = rscale_ff;
      rwin_in = rwin_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in = out_ff;
      n9 = 9'd0;
      idx = 8'd0;
      acc_fin = acc_ff;
      finish = 1'b0;
      val = 32'd0;
      sh = 4'd0;
      raw_win = 16'd0;

      if (take) begin
         if (p7 < 7'd20) begin
            if (p7 >= 7'd4 && p7 <= 7'd7) begin
               ack_num_in = {ack_num_ff[23:0], b};
            end else if (p7 == 7'd12) begin
               words_in = b[7:4];
            end else if (p7 == 7'd13) begin
               ack_flag_in = b[4];
               if (b[4]) begin
                  if (lack_ff == ack_num_ff && q_item.send_next != ack_num_ff) begin
                     if (dup_ff != 16'hFFFF) begin
                        dup_in = dup_ff + 16'd1;
                     end
                  end else begin
                     dup_in = 16'd0;
                  end
                  lack_in = ack_num_ff;
               end
            end else if (p7 == 7'd14) begin
               win_hi_in = b;
            end else if (p7 == 7'd15) begin
               raw_win = {win_hi_ff, b};
               sh = (sscale_ff > 8'd14) ? thop_pkg::MaxScale : sscale_ff[3:0];
               swin_in = 30'({14'd0, raw_win} << sh);
            end
         end else if (p7 < end_pos && !stopped_ff) begin
            unique case (phase_ff)
               thop_pkg::PH_KIND: begin
                  kind_in = b;
                  if (b == thop_pkg::KIND_EOL) begin
                     stopped_in = 1'b1;
                  end else if (b == thop_pkg::KIND_NOP) begin
                     phase_in = thop_pkg::PH_KIND;
                  end else if (p7 + 7'd1 >= end_pos) begin
                     stopped_in = 1'b1;
                     err_in = 1'b1;
                  end else begin
                     phase_in = thop_pkg::PH_LEN;
                  end
               end
               thop_pkg::PH_LEN: begin
                  n9 = {1'b0, b} - 9'd2;
                  if (b < 8'd2) begin
                     stopped_in = 1'b1;
                     err_in = 1'b1;
                  end else if ({2'b0, p7} + 9'd1 + n9 > {2'b0, end_pos}) begin
                     stopped_in = 1'b1;
                     err_in = 1'b1;
                  end else begin
                     olen_in = n9[7:0];
                     remain_in = n9[7:0];
                     acc_in = 64'd0;
                     acc_fin = 64'd0;
                     if (n9 == 9'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = thop_pkg::PH_DATA;
                     end
                  end
               end
               default: begin
                  idx = olen_ff - remain_ff;
                  if (idx < 8'd8) begin
                     acc_fin = acc_ff | ({56'd0, b} << (6'd56 - {idx[2:0], 3'b000}));
                  end
                  acc_in = acc_fin;
                  remain_in = remain_ff - 8'd1;
                  if (remain_ff == 8'd1) begin
                     finish = 1'b1;
                  end
               end
            endcase
            if (finish) begin
               phase_in = thop_pkg::PH_KIND;
               val = opt_value(acc_fin, olen_in);
               priority if (kind_ff == thop_pkg::KIND_MSS) begin
                  if (val != 32'd0 && val < {16'd0, mss_ff}) begin
                     mss_in = val[15:0];
                  end
               end else if (kind_ff == thop_pkg::KIND_WSCALE) begin
                  sscale_in = val[7:0];
                  rscale_in = (local_window_scale > thop_pkg::MaxScale) ?
                     thop_pkg::MaxScale : local_window_scale;
                  rwin_in = local_window_size;
               end else if (kind_ff == thop_pkg::KIND_SACK_OK) begin
                  sack_in = 1'b1;
               end else if (kind_ff == thop_pkg::KIND_SACK) begin
                  sack_in = sack_ff;
               end else if (kind_ff == thop_pkg::KIND_TSTAMP) begin
                  pts_in = acc_fin[63:32];
                  if (ack_flag_ff) begin
                     ets_in = acc_fin[31:0];
                  end
               end else begin
                  stopped_in = 1'b1;
                  err_in = 1'b1;
               end
            end
         end

         if (q_item.last) begin
            out_valid_in = 1'b1;
            out_in.send_window = swin_in;
            out_in.dup_ack_count = dup_in;
            out_in.latest_ack = lack_in;
            out_in.peer_mss = mss_in;
            out_in.send_scale = sscale_in;
            out_in.sack_allowed = sack_in;
            out_in.peer_timestamp = pts_in;
            out_in.echoed_timestamp = ets_in;
            out_in.recv_scale = rscale_in;
            out_in.recv_window = rwin_in;
            out_in.parse_error = err_in || (!stopped_in && p_next < end_pos);
            words_in = 4'd0;
            ack_flag_in = 1'b0;
            ack_num_in = 32'd0;
            win_hi_in = 8'd0;
            phase_in = thop_pkg::PH_KIND;
            kind_in = 8'd0;
            remain_in = 8'd0;
            olen_in = 8'd0;
            acc_in = 64'd0;
            stopped_in = 1'b0;
            err_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_ff <= 4'd0;
         ack_flag_ff <= 1'b0;
         ack_num_ff <= 32'd0;
         win_hi_ff <= 8'd0;
         phase_ff <= thop_pkg::PH_KIND;
         kind_ff <= 8'd0;
         remain_ff <= 8'd0;
         olen_ff <= 8'd0;
         acc_ff <= 64'd0;
         stopped_ff <= 1'b0;
         err_ff <= 1'b0;
         swin_ff <= 30'd0;
         lack_ff <= 32'd0;
         dup_ff <= 16'd0;
         mss_ff <= thop_pkg::DefaultMss;
         sscale_ff <= 8'd0;
         sack_ff <= 1'b0;
         pts_ff <= 32'd0;
         ets_ff <= 32'd0;
         rscale_ff <= 4'd0;
         rwin_ff <= 30'd1460;
         out_valid_ff <= 1'b0;
      end else begin
         words_ff <= words_in;
         ack_flag_ff <= ack_flag_in;
         ack_num_ff <= ack_num_in;
         win_hi_ff <= win_hi_in;
         phase_ff <= phase_in;
         kind_ff <= kind_in;
         remain_ff <= remain_in;
         olen_ff <= olen_in;
         acc_ff <= acc_in;
         stopped_ff <= stopped_in;
         err_ff <= err_in;
         swin_ff <= swin_in;
         lack_ff <= lack_in;
         dup_ff <= dup_in;
         mss_ff <= mss_in;
         sscale_ff <= sscale_in;
         sack_ff <= sack_in;
         pts_ff <= pts_in;
         ets_ff <= ets_in;
         rscale_ff <= rscale_in;
         rwin_ff <= rwin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

### hw/rtl/tcp_header_option_parser_unit.sv
// Channel   Direction  Transfer when            Carries
// req_*     in         req_valid && !req_stall  one header byte, end mark, send-next
// rsp_*     out        rsp_valid && !rsp_stall  parse result, one per header
// csr_*     in         csr_write_enable         local window size and scale
//
// One header byte is taken in every cycle unless req_stall holds it; the option
// walker in the back part sets that rate. The last byte of a header passes
// through the queue, and the back part registers the result of the header on
// the edge at which it takes that byte.
// Reset is synchronous and active high and clears all parse and peer state.
// A stalled result is held in its register while the queue keeps absorbing
// bytes; the request side stalls only once the two-entry queue is full.
module tcp_header_option_parser_unit #(
   parameter int MaxHeaderBytes = thop_pkg::MaxHeaderBytes,
   parameter int QueueDepth = thop_pkg::QueueDepth
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [7:0] req_header_byte,
   input logic req_last_byte,
   input logic [31:0] req_send_next,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [29:0] rsp_send_window,
   output logic [15:0] rsp_dup_ack_count,
   output logic [31:0] rsp_last_ack,
   output logic [15:0] rsp_peer_mss,
   output logic [7:0] rsp_send_scale,
   output logic rsp_sack_allowed,
   output logic [31:0] rsp_peer_timestamp,
   output logic [31:0] rsp_echoed_timestamp,
   output logic [3:0] rsp_recv_scale,
   output logic [29:0] rsp_recv_window,
   output logic rsp_parse_error,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [thop_pkg::CsrDataWidth-1:0] csr_write_data
);

   logic [29:0] lwin_ff;
   logic [3:0] lscale_ff;

   // Configuration registers: user must write only while block is idle; unchecked.
   always_ff @(posedge clock) begin
      if (reset) begin
         lwin_ff <= thop_pkg::ResetLocalWindow;
         lscale_ff <= 4'd0;
      end else if (csr_write_enable) begin
         unique case (thop_pkg::csr_index_type'(csr_index))
            thop_pkg::CSR_LOCAL_WINDOW_SIZE: lwin_ff <= csr_write_data[29:0];
            thop_pkg::CSR_LOCAL_WINDOW_SCALE: lscale_ff <= csr_write_data[3:0];
            default: lwin_ff <= lwin_ff;
         endcase
      end
   end

   logic f_valid, f_ready, b_valid, b_ready;
   thop_pkg::item_type f_item, b_item;
   thop_pkg::result_type res;

   thop_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_header_byte(req_header_byte), .req_last_byte(req_last_byte),
      .req_send_next(req_send_next),
      .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
   );

   thop_queue #(.Depth(QueueDepth)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
   );

   thop_back #(.MaxHeaderBytes(MaxHeaderBytes)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
      .local_window_size(lwin_ff), .local_window_scale(lscale_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(res)
   );

   assign rsp_send_window = res.send_window;
   assign rsp_dup_ack_count = res.dup_ack_count;
   assign rsp_last_ack = res.latest_ack;
   assign rsp_peer_mss = res.peer_mss;
   assign rsp_send_scale = res.send_scale;
   assign rsp_sack_allowed = res.sack_allowed;
   assign rsp_peer_timestamp = res.peer_timestamp;
   assign rsp_echoed_timestamp = res.echoed_timestamp;
   assign rsp_recv_scale = res.recv_scale;
   assign rsp_recv_window = res.recv_window;
   assign rsp_parse_error = res.parse_error;

endmodule

### verif/thop_parse_monitor.sv
module thop_parse_monitor (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic [7:0] req_header_byte,
   input logic req_last_byte,
   input logic [31:0] req_send_next,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [29:0] rsp_send_window,
   input logic [15:0] rsp_dup_ack_count,
   input logic [31:0] rsp_last_ack,
   input logic [15:0] rsp_peer_mss,
   input logic [7:0] rsp_send_scale,
   input logic rsp_sack_allowed,
   input logic [31:0] rsp_peer_timestamp,
   input logic [31:0] rsp_echoed_timestamp,
   input logic [3:0] rsp_recv_scale,
   input logic [29:0] rsp_recv_window,
   input logic rsp_parse_error,
   input logic csr_write_enable,
   input logic csr_index,
   input logic [thop_pkg::CsrDataWidth-1:0] csr_write_data,
   output int mismatches,
   output int outstanding
);

   // Register copies.
   logic [29:0] cfg_window;
   logic [3:0] cfg_scale;

   // Per-header parse state.
   int pos;
   logic [3:0] data_words;
   logic ack_seen;
   logic [31:0] ack_value;
   logic [15:0] peer_window;
   thop_pkg::phase_type phase;
   logic [7:0] kind;
   int remaining;
   int opt_len;
   logic [63:0] opt_data;
   logic halted;
   logic error_seen;

   // State kept across headers.
   logic [29:0] scaled_window;
   logic [31:0] acked;
   logic [15:0] dup_acks;
   logic [15:0] mss;
   logic [7:0] peer_shift;
   logic sack_ok;
   logic [31:0] ts_value;
   logic [31:0] ts_echo;
   logic [3:0] local_shift;
   logic [29:0] local_window;

   thop_pkg::result_type parse_results[$];

   function automatic void clear_header();
      pos = 0;
      data_words = '0;
      ack_seen = 1'b0;
      ack_value = '0;
      peer_window = '0;
      phase = thop_pkg::PH_KIND;
      kind = '0;
      remaining = 0;
      opt_len = 0;
      opt_data = '0;
      halted = 1'b0;
      error_seen = 1'b0;
   endfunction

   function automatic void abort_walk();
      halted = 1'b1;
      error_seen = 1'b1;
   endfunction

   // Big-endian value of the first (at most four) option data bytes.
   function automatic logic [31:0] leading_value(int n);
      int m;
      m = (n > 4) ? 4 : n;
      if (m == 0) return '0;
      return opt_data[63:32] >> (32 - 8 * m);
   endfunction

   function automatic void close_option();
      logic [31:0] v;
      phase = thop_pkg::PH_KIND;
      v = leading_value(opt_len);
      case (kind)
         thop_pkg::KIND_MSS: begin
            if (v != 0 && v < mss) mss = v[15:0];
         end
         thop_pkg::KIND_WSCALE: begin
            peer_shift = v[7:0];
            local_shift = (cfg_scale > thop_pkg::MaxScale) ? thop_pkg::MaxScale : cfg_scale;
            local_window = cfg_window;
         end
         thop_pkg::KIND_SACK_OK: sack_ok = 1'b1;
         thop_pkg::KIND_SACK: ;
         thop_pkg::KIND_TSTAMP: begin
            ts_value = opt_data[63:32];
            if (ack_seen) ts_echo = opt_data[31:0];
         end
         default: abort_walk();
      endcase
   endfunction

   function automatic void walk_option(int p, logic [7:0] b, int area);
      int n;
      int idx;
      case (phase)
         thop_pkg::PH_KIND: begin
            kind = b;
            if (b == thop_pkg::KIND_EOL) halted = 1'b1;
            else if (b == thop_pkg::KIND_NOP) ;
            else if (p + 1 >= area) abort_walk();
            else phase = thop_pkg::PH_LEN;
         end
         thop_pkg::PH_LEN: begin
            n = int'(b) - 2;
            if (b < 2) abort_walk();
            else if (p + 1 + n > area) abort_walk();
            else begin
               opt_len = n;
               remaining = n;
               opt_data = '0;
               if (n == 0) close_option();
               else phase = thop_pkg::PH_DATA;
            end
         end
         default: begin
            idx = opt_len - remaining;
            if (idx < 8) opt_data[63 - 8 * idx -: 8] = b;
            remaining--;
            if (remaining == 0) close_option();
         end
      endcase
   endfunction

   function automatic void take_byte(logic [7:0] b, logic last, logic [31:0] snd);
      int p;
      int area;
      int shift;
      logic [31:0] wide;
      thop_pkg::result_type r;
      p = pos;
      area = (data_words < 5) ? 20 : int'(data_words) * 4;
      if (area > thop_pkg::MaxHeaderBytes) area = thop_pkg::MaxHeaderBytes;
      if (p < 20) begin
         if (p >= 4 && p <= 7) begin
            ack_value = {ack_value[23:0], b};
         end else if (p == 12) begin
            data_words = b[7:4];
         end else if (p == 13) begin
            ack_seen = b[4];
            if (ack_seen) begin
               if (acked == ack_value && snd != ack_value) begin
                  if (dup_acks != 16'hFFFF) dup_acks++;
               end else begin
                  dup_acks = '0;
               end
               acked = ack_value;
            end
         end else if (p == 14) begin
            peer_window = {b, 8'h00};
         end else if (p == 15) begin
            peer_window[7:0] = b;
            shift = (peer_shift > 14) ? 14 : int'(peer_shift);
            wide = {16'h0000, peer_window} << shift;
            scaled_window = wide[29:0];
         end
      end else if (p < area && !halted) begin
         walk_option(p, b, area);
      end
      if (pos < 63) pos++;
      if (last) begin
         if (!halted && pos < area) error_seen = 1'b1;
         r.send_window = scaled_window;
         r.dup_ack_count = dup_acks;
         r.latest_ack = acked;
         r.peer_mss = mss;
         r.send_scale = peer_shift;
         r.sack_allowed = sack_ok;
         r.peer_timestamp = ts_value;
         r.echoed_timestamp = ts_echo;
         r.recv_scale = local_shift;
         r.recv_window = local_window;
         r.parse_error = error_seen;
         parse_results.push_back(r);
         clear_header();
      end
   endfunction

   always @(posedge clock) begin
      thop_pkg::result_type got;
      thop_pkg::result_type want;
      if (reset) begin
         mismatches = 0;
         cfg_window = thop_pkg::ResetLocalWindow;
         cfg_scale = '0;
         clear_header();
         scaled_window = '0;
         acked = '0;
         dup_acks = '0;
         mss = thop_pkg::DefaultMss;
         peer_shift = '0;
         sack_ok = 1'b0;
         ts_value = '0;
         ts_echo = '0;
         local_shift = '0;
         local_window = 30'd1460;
         parse_results.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == thop_pkg::CSR_LOCAL_WINDOW_SIZE) cfg_window = csr_write_data[29:0];
            else cfg_scale = csr_write_data[3:0];
         end
         if (req_valid && !req_stall)
            take_byte(req_header_byte, req_last_byte, req_send_next);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_send_window, rsp_dup_ack_count, rsp_last_ack, rsp_peer_mss,
                   rsp_send_scale, rsp_sack_allowed, rsp_peer_timestamp,
                   rsp_echoed_timestamp, rsp_recv_scale, rsp_recv_window,
                   rsp_parse_error};
            if (parse_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result transfer: %p", got);
            end else begin
               want = parse_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result mismatch at %0t", $time);
                     $display("  expected %p", want);
                     $display("  actual   %p", got);
                  end
               end
            end
         end
      end
      outstanding = parse_results.size();
   end

endmodule

### verif/tcp_header_option_parser_unit_tb.sv
module tcp_header_option_parser_unit_tb;

   // The watchdog ends the run after this many cycles without any transfer.
   localparam int IdleLimit = 5000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_header_byte;
   logic req_last_byte;
   logic [31:0] req_send_next;
   logic rsp_valid;
   logic rsp_stall;
   logic [29:0] rsp_send_window;
   logic [15:0] rsp_dup_ack_count;
   logic [31:0] rsp_last_ack;
   logic [15:0] rsp_peer_mss;
   logic [7:0] rsp_send_scale;
   logic rsp_sack_allowed;
   logic [31:0] rsp_peer_timestamp;
   logic [31:0] rsp_echoed_timestamp;
   logic [3:0] rsp_recv_scale;
   logic [29:0] rsp_recv_window;
   logic rsp_parse_error;
   logic csr_write_enable;
   logic csr_index;
   logic [thop_pkg::CsrDataWidth-1:0] csr_write_data;

   int mismatches;
   int outstanding;

   // The header being assembled, the ack number reused to provoke duplicate
   // acknowledgements, and the count of byte transfers made so far.
   logic [7:0] hdr[$];
   logic [31:0] prev_ack;
   int bytes_sent;

   tcp_header_option_parser_unit dut (.*);

   thop_parse_monitor u_monitor (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response side: a random stall is drawn before each result, with stretches
   // in which the receiver never stalls at all.
   initial begin
      int wait_cycles;
      bit eager;
      rsp_stall = 1'b0;
      eager = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0) eager = ~eager;
         wait_cycles = eager ? 0 : $urandom_range(0, 9);
         if (wait_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Watchdog: any transfer on any port restarts the count.
   initial begin
      int idle;
      idle = 0;
      while (idle < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable
             || reset)
            idle = 0;
         else
            idle++;
      end
      $display("Timeout after %0d cycles without a transfer", IdleLimit);
      $display("Mismatches found");
      $finish;
   end

   task automatic write_register(input thop_pkg::csr_index_type idx,
                                 input logic [29:0] value);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Waits until every predicted result has been collected, then keeps waiting
   // so that the block's pipeline is empty too.
   task automatic drain();
      while (outstanding != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // The sixteen leading bytes: ack number, data offset, flags and window.
   task automatic add_fixed(input int words, input bit ack_set);
      logic [7:0] flags;
      hdr.delete();
      repeat (4) hdr.push_back(8'($urandom));
      if ($urandom_range(0, 2) == 0) prev_ack = $urandom;
      for (int i = 3; i >= 0; i--) hdr.push_back(prev_ack[8 * i +: 8]);
      repeat (4) hdr.push_back(8'($urandom));
      hdr.push_back({4'(words), 4'($urandom)});
      flags = 8'($urandom);
      flags[4] = ack_set;
      hdr.push_back(flags);
      repeat (2) hdr.push_back(8'($urandom));
   endtask

   function automatic int area_end(int words);
      return (words < 5) ? 20 : words * 4;
   endfunction

   task automatic pad_to(input int area);
      while (hdr.size() < area) hdr.push_back(thop_pkg::KIND_NOP);
   endtask

   // Appends one option with random content; if it would not fit, the rest
   // of the option area is filled with no-operation bytes instead.
   task automatic add_option(input logic [7:0] kind, input int len, input int area);
      if (kind == thop_pkg::KIND_EOL || kind == thop_pkg::KIND_NOP) begin
         hdr.push_back(kind);
      end else if (hdr.size() + len > area) begin
         pad_to(area);
      end else begin
         hdr.push_back(kind);
         hdr.push_back(8'(len));
         for (int i = 0; i < len - 2; i++) begin
            if (kind == thop_pkg::KIND_WSCALE) hdr.push_back(8'($urandom_range(0, 16)));
            else if (kind == thop_pkg::KIND_MSS && i == 0)
               hdr.push_back(8'($urandom_range(0, 7)));
            else hdr.push_back(8'($urandom));
         end
      end
   endtask

   // Styles: mostly well-formed option lists, some corrupted, truncated,
   // overlong or pure noise.
   task automatic build_header();
      int words;
      int area;
      int style;
      int pick;
      logic [7:0] odd_kinds[3];
      odd_kinds = '{thop_pkg::KIND_MSS, thop_pkg::KIND_WSCALE, thop_pkg::KIND_TSTAMP};
      style = $urandom_range(0, 19);
      if (style == 19) begin
         hdr.delete();
         repeat ($urandom_range(1, 70)) hdr.push_back(8'($urandom));
         return;
      end
      words = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
      area = area_end(words);
      add_fixed(words, $urandom_range(0, 4) != 0);
      while (hdr.size() < area) begin
         pick = $urandom_range(0, 19);
         if (pick < 5) add_option(thop_pkg::KIND_NOP, 1, area);
         else if (pick < 7) add_option(thop_pkg::KIND_MSS, 4, area);
         else if (pick < 9) add_option(thop_pkg::KIND_WSCALE, 3, area);
         else if (pick < 11) add_option(thop_pkg::KIND_SACK_OK, 2, area);
         else if (pick < 14) add_option(thop_pkg::KIND_TSTAMP, 10, area);
         else if (pick == 14)
            add_option(thop_pkg::KIND_SACK, 2 + 8 * $urandom_range(0, 3), area);
         else if (pick == 15)
            add_option(odd_kinds[$urandom_range(0, 2)], $urandom_range(2, 12), area);
         else if (pick == 16) begin
            hdr.push_back(thop_pkg::KIND_EOL);
            while (hdr.size() < area) hdr.push_back(8'($urandom));
         end else if (pick == 17) begin
            add_option(8'($urandom_range(6, 255)), $urandom_range(2, 6), area);
         end else begin
            add_option(thop_pkg::KIND_NOP, 1, area);
         end
      end
      if (style == 16 && hdr.size() > 20)
         hdr[$urandom_range(20, hdr.size() - 1)] = 8'($urandom_range(0, 3));
      else if (style == 17)
         repeat ($urandom_range(1, hdr.size())) void'(hdr.pop_back());
      else if (style == 18)
         while (hdr.size() < $urandom_range(61, 72)) hdr.push_back(8'($urandom));
   endtask

   task automatic send_header();
      bit eager;
      int gap;
      eager = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < hdr.size(); i++) begin
         gap = eager ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_header_byte = hdr[i];
         req_last_byte = (i == hdr.size() - 1);
         // Only the flags byte samples send_next; half the time it matches
         // the ack number so that the duplicate test sees both outcomes.
         req_send_next = (i == 13 && $urandom_range(0, 1) == 1) ? prev_ack : $urandom;
         req_valid = 1'b1;
         do @(posedge clock); while (req_stall);
         @(negedge clock);
         bytes_sent++;
      end
   endtask

   // Directed headers covering every option kind and each malformed case.
   task automatic directed_headers();
      // Bare sixteen-byte header, then one with a zero data offset.
      add_fixed(5, 1'b1);
      send_header();
      add_fixed(0, 1'b1);
      send_header();
      // Sixty-byte header whose MSS option lies in the fixed bytes; the walker
      // sees all other kinds and a window scale shift far above the clamp.
      add_fixed(15, 1'b1);
      hdr = {hdr, thop_pkg::KIND_MSS, 8'd4, 8'h02, 8'h00, thop_pkg::KIND_WSCALE, 8'd3,
             8'd200, thop_pkg::KIND_SACK_OK, 8'd2, thop_pkg::KIND_TSTAMP, 8'd10, 8'hFF,
             8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, thop_pkg::KIND_NOP,
             thop_pkg::KIND_SACK, 8'd10};
      repeat (8) hdr.push_back(8'($urandom));
      hdr.push_back(thop_pkg::KIND_EOL);
      while (hdr.size() < 60) hdr.push_back(8'hFF);
      send_header();
      // The window is now shifted by the clamped scale.
      add_fixed(5, 1'b1);
      hdr[14] = 8'hFF;
      hdr[15] = 8'hFF;
      send_header();
      // Length bytes of zero and one.
      add_fixed(6, 1'b1);
      hdr = {hdr, thop_pkg::KIND_MSS, 8'd1, 8'd0, 8'd0};
      send_header();
      add_fixed(6, 1'b1);
      hdr = {hdr, thop_pkg::KIND_MSS, 8'd0, 8'd0, 8'd0};
      send_header();
      // Option data running past the end of the area.
      add_fixed(6, 1'b1);
      hdr = {hdr, thop_pkg::KIND_TSTAMP, 8'd10, 8'd1, 8'd2};
      send_header();
      // A kind in the last byte of the header, with no length byte after it.
      add_fixed(6, 1'b1);
      hdr = {hdr, thop_pkg::KIND_NOP, thop_pkg::KIND_NOP, thop_pkg::KIND_NOP,
             thop_pkg::KIND_MSS};
      send_header();
      // Unknown kind with its data.
      add_fixed(6, 1'b1);
      hdr = {hdr, 8'd9, 8'd4, 8'hAA, 8'h55};
      send_header();
      // Timestamp without the ack flag, and one that is short of data.
      add_fixed(8, 1'b0);
      hdr = {hdr, thop_pkg::KIND_NOP, thop_pkg::KIND_NOP, thop_pkg::KIND_TSTAMP, 8'd10,
             8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0};
      send_header();
      add_fixed(6, 1'b1);
      hdr = {hdr, thop_pkg::KIND_TSTAMP, 8'd4, 8'h01, 8'h02};
      send_header();
      // Header that ends before its option area.
      add_fixed(10, 1'b1);
      hdr = {hdr, thop_pkg::KIND_NOP, thop_pkg::KIND_NOP};
      send_header();
      // Header longer than any allowed, so that the byte position saturates.
      add_fixed(5, 1'b1);
      repeat (52) hdr.push_back(8'($urandom));
      send_header();
      // Header cut off before the flags byte.
      add_fixed(5, 1'b1);
      repeat (10) void'(hdr.pop_back());
      send_header();
   endtask

   initial begin
      logic [29:0] window_settings[5];
      logic [29:0] scale_settings[5];
      window_settings = '{30'd65535, 30'd0, 30'h3FFF_FFFF, 30'($urandom), 30'd1};
      scale_settings = '{30'd0, 30'd15, 30'd14, 30'($urandom), 30'h3FFF_FFF1};
      reset = 1'b1;
      req_valid = 1'b0;
      req_header_byte = '0;
      req_last_byte = 1'b0;
      req_send_next = '0;
      csr_write_enable = 1'b0;
      csr_index = thop_pkg::CSR_LOCAL_WINDOW_SIZE;
      csr_write_data = '0;
      prev_ack = '0;
      bytes_sent = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_headers();

      // Random traffic in phases, with the local window registers changed
      // between phases while the block is idle.
      for (int ph = 0; ph < 5; ph++) begin
         req_valid = 1'b0;
         drain();
         write_register(thop_pkg::CSR_LOCAL_WINDOW_SIZE, window_settings[ph]);
         write_register(thop_pkg::CSR_LOCAL_WINDOW_SCALE, scale_settings[ph]);
         while (bytes_sent < 400 + 160 * (ph + 1)) begin
            build_header();
            send_header();
         end
      end
      req_valid = 1'b0;
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### tcp_header_option_parser_unit.f
hw/rtl/thop_pkg.sv
hw/rtl/thop_front.sv
hw/rtl/thop_queue.sv
hw/rtl/thop_back.sv
hw/rtl/tcp_header_option_parser_unit.sv
verif/thop_parse_monitor.sv
verif/tcp_header_option_parser_unit_tb.sv
